// File: rtl/coordinate_polar_converter_unit_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef COORDINATE_POLAR_CONVERTER_UNIT_DEFINES_SVH
`define COORDINATE_POLAR_CONVERTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define CPC_ASSERT_LATER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// File: rtl/cpc_pkg.sv
package cpc_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int ANGLE_WIDTH    = 16;
  localparam int MAG_WIDTH      = COORD_WIDTH + 1;
  localparam int GUARD          = 8;
  localparam int DATA_W         = COORD_WIDTH + GUARD + 4;
  localparam int ITERATIONS_DEF = 16;
  localparam int TABLE_LEN      = 24;
  localparam int KGAIN_W        = 17;
  localparam int PROD_W         = DATA_W + KGAIN_W;
  localparam int UNSCALE_SH     = 16 + GUARD;
  localparam int ANG_SH         = 9;
  localparam int ANG_IN_SH      = 9;
  localparam int ANG_OUT_MAX    = 23040;
  localparam int MAG_MAX        = 2 ** COORD_WIDTH - 1;
  localparam int COORD_MAX      = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int COORD_MIN      = -(2 ** (COORD_WIDTH - 1));

  localparam logic signed [KGAIN_W-1:0] KGAIN      = KGAIN_W'(39797);
  localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) <<< (UNSCALE_SH - 1);
  localparam logic signed [DATA_W-1:0]  ANG_HALF   = DATA_W'(1) <<< (ANG_SH - 1);
  localparam logic signed [DATA_W-1:0]  DEG90      = DATA_W'(90 * 65536);
  localparam logic signed [DATA_W-1:0]  DEG180     = DATA_W'(180 * 65536);
  localparam logic signed [DATA_W-1:0]  DEG360     = DATA_W'(360 * 65536);

  // One item in flight through the rotation stages.
  typedef struct packed {
    logic                     func;
    logic                     org;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } cpc_item_t;

  // Arctangent of 2^-idx in degrees with 16 fraction bits.
  function automatic logic signed [DATA_W-1:0] atan_deg(input int unsigned idx);
    logic signed [DATA_W-1:0] v;
    case (idx)
      0:       v = DATA_W'(2949120);
      1:       v = DATA_W'(1740967);
      2:       v = DATA_W'(919879);
      3:       v = DATA_W'(466945);
      4:       v = DATA_W'(234379);
      5:       v = DATA_W'(117304);
      6:       v = DATA_W'(58666);
      7:       v = DATA_W'(29335);
      8:       v = DATA_W'(14668);
      9:       v = DATA_W'(7334);
      10:      v = DATA_W'(3667);
      11:      v = DATA_W'(1833);
      12:      v = DATA_W'(917);
      13:      v = DATA_W'(458);
      14:      v = DATA_W'(229);
      15:      v = DATA_W'(115);
      16:      v = DATA_W'(57);
      17:      v = DATA_W'(29);
      18:      v = DATA_W'(14);
      19:      v = DATA_W'(7);
      20:      v = DATA_W'(4);
      21:      v = DATA_W'(2);
      22:      v = DATA_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/cpc_stage.sv
module cpc_stage import cpc_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  cpc_item_t in_item,
  output logic      out_vld,
  output cpc_item_t out_item
);

  localparam logic signed [DATA_W-1:0] ATAN = atan_deg(SHIFT);

  logic                     rot;
  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  cpc_item_t                item_next;

  // Vectoring drives y to zero, rotation drives z to zero; both reduce to
  // one sign choice for the micro-rotation.
  always_comb begin
    xs  = in_item.x >>> SHIFT;
    ys  = in_item.y >>> SHIFT;
    rot = in_item.func ? ~in_item.z[DATA_W-1] : in_item.y[DATA_W-1];
    item_next      = in_item;
    item_next.x    = rot ? in_item.x - ys   : in_item.x + ys;
    item_next.y    = rot ? in_item.y + xs   : in_item.y - xs;
    item_next.z    = rot ? in_item.z - ATAN : in_item.z + ATAN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= item_next;
  end

endmodule

// File: rtl/coordinate_polar_converter_unit.sv
// Pipelined CORDIC coordinate converter. One request may be issued in every
// clock cycle; a request is taken when start is high and busy is low, and
// busy is high only while rst is asserted. Each result passes through one
// input stage, one stage per micro-rotation, one gain-multiply stage and
// one rounding stage; results come out in request order, and each one is
// marked by done for exactly one cycle. There is no back-pressure: the
// receiver must capture out_first and out_second whenever done is high.
// With func low, in_first/in_second are x/y in Q7.8 and the result is the
// magnitude (unsigned Q9.8) and the angle in Q8.7 degrees; with func high
// they are magnitude and angle and the result is x/y in Q7.8, saturated.
`include "coordinate_polar_converter_unit_defines.svh"

module coordinate_polar_converter_unit import cpc_pkg::*; #(
  parameter int unsigned ITERATIONS = ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic signed [COORD_WIDTH-1:0] in_first,
  input  logic signed [COORD_WIDTH-1:0] in_second,
  output logic                          done,
  output logic signed [MAG_WIDTH-1:0]   out_first,
  output logic signed [ANGLE_WIDTH-1:0] out_second
);

  localparam int unsigned LATENCY = ITERATIONS + 3;

  logic                     accept;
  logic                     neg;
  logic                     fold_hi;
  logic                     fold_lo;
  logic signed [DATA_W-1:0] a_ext;
  logic signed [DATA_W-1:0] b_ext;
  logic signed [DATA_W-1:0] z_raw;
  logic signed [DATA_W-1:0] r_fold;
  cpc_item_t                pre_next;

  logic      vld_pipe  [0:ITERATIONS];
  cpc_item_t item_pipe [0:ITERATIONS];

  logic                     p1_vld;
  logic                     p1_func;
  logic                     p1_org;
  logic signed [PROD_W-1:0] p1_px;
  logic signed [PROD_W-1:0] p1_py;
  logic signed [DATA_W-1:0] p1_z;
  logic signed [DATA_W-1:0] z_wrap;

  logic signed [PROD_W-1:0] ux;
  logic signed [PROD_W-1:0] uy;
  logic signed [PROD_W-1:0] first_sat;
  logic signed [PROD_W-1:0] second_sat;
  logic signed [DATA_W-1:0] ang;
  logic signed [DATA_W-1:0] ang_sat;
  logic signed [MAG_WIDTH-1:0]   out_first_next;
  logic signed [ANGLE_WIDTH-1:0] out_second_next;

  assign busy   = rst;
  assign accept = start & ~busy;

  // Input stage: half-plane fold for vectoring, quadrant fold for rotation.
  // An input angle lies within +-256 degrees, so the 360 degree wrap and the
  // 180 degree fold collapse into a single add.
  always_comb begin
    a_ext   = DATA_W'(in_first);
    b_ext   = DATA_W'(in_second);
    z_raw   = b_ext <<< ANG_IN_SH;
    neg     = in_first[COORD_WIDTH-1];
    fold_hi = z_raw > DEG90;
    fold_lo = z_raw < -DEG90;
    r_fold  = (fold_hi | fold_lo) ? -a_ext : a_ext;
    pre_next      = '0;
    pre_next.func = func;
    if (!func) begin
      pre_next.org = (in_first == '0) && (in_second == '0);
      pre_next.x   = (neg ? -a_ext : a_ext) <<< GUARD;
      pre_next.y   = (neg ? -b_ext : b_ext) <<< GUARD;
      pre_next.z   = neg ? DEG180 : '0;
    end else begin
      pre_next.x = r_fold <<< GUARD;
      pre_next.y = '0;
      if (fold_hi) begin
        pre_next.z = z_raw - DEG180;
      end else if (fold_lo) begin
        pre_next.z = z_raw + DEG180;
      end else begin
        pre_next.z = z_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe[0] <= 1'b0;
    end else begin
      vld_pipe[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    item_pipe[0] <= pre_next;
  end

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
    cpc_stage #(
      .SHIFT (g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (vld_pipe[g]),
      .in_item  (item_pipe[g]),
      .out_vld  (vld_pipe[g+1]),
      .out_item (item_pipe[g+1])
    );
  end

  // Gain removal multiply and angle wrap into (-180, 180].
  always_comb begin
    if (item_pipe[ITERATIONS].z > DEG180) begin
      z_wrap = item_pipe[ITERATIONS].z - DEG360;
    end else if (item_pipe[ITERATIONS].z <= -DEG180) begin
      z_wrap = item_pipe[ITERATIONS].z + DEG360;
    end else begin
      z_wrap = item_pipe[ITERATIONS].z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= vld_pipe[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    p1_func <= item_pipe[ITERATIONS].func;
    p1_org  <= item_pipe[ITERATIONS].org;
    p1_px   <= PROD_W'(item_pipe[ITERATIONS].x) * PROD_W'(KGAIN);
    p1_py   <= PROD_W'(item_pipe[ITERATIONS].y) * PROD_W'(KGAIN);
    p1_z    <= z_wrap;
  end

  // Rounding and saturation into the output formats.
  always_comb begin
    ux  = (p1_px + ROUND_HALF) >>> UNSCALE_SH;
    uy  = (p1_py + ROUND_HALF) >>> UNSCALE_SH;
    ang = (p1_z + ANG_HALF) >>> ANG_SH;
    if (ang > ANG_OUT_MAX) begin
      ang_sat = DATA_W'(ANG_OUT_MAX);
    end else if (ang < -ANG_OUT_MAX) begin
      ang_sat = -DATA_W'(ANG_OUT_MAX);
    end else begin
      ang_sat = ang;
    end
    if (!p1_func) begin
      if (ux > MAG_MAX) begin
        first_sat = PROD_W'(MAG_MAX);
      end else if (ux < 0) begin
        first_sat = '0;
      end else begin
        first_sat = ux;
      end
      second_sat = PROD_W'(ang_sat);
    end else begin
      if (ux > COORD_MAX) begin
        first_sat = PROD_W'(COORD_MAX);
      end else if (ux < COORD_MIN) begin
        first_sat = PROD_W'(COORD_MIN);
      end else begin
        first_sat = ux;
      end
      if (uy > COORD_MAX) begin
        second_sat = PROD_W'(COORD_MAX);
      end else if (uy < COORD_MIN) begin
        second_sat = PROD_W'(COORD_MIN);
      end else begin
        second_sat = uy;
      end
    end
    if (p1_org) begin
      out_first_next  = '0;
      out_second_next = '0;
    end else begin
      out_first_next  = MAG_WIDTH'(first_sat);
      out_second_next = ANGLE_WIDTH'(second_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_first  <= out_first_next;
    out_second <= out_second_next;
  end

  `CPC_ASSERT_LATER(a_req_gives_done, accept, LATENCY, done,
                    "request did not produce a result at the pipeline latency")

  `CPC_ASSERT_NOW(a_done_has_req, done, $past(accept, LATENCY),
                  "result strobe without a matching request")

  `CPC_ASSERT_LATER(a_origin_zero,
                    accept && !func && in_first == '0 && in_second == '0, LATENCY,
                    out_first == '0 && out_second == '0,
                    "origin did not give zero magnitude and angle")

  `CPC_ASSERT_NOW(a_polar_range, done && !$past(func, LATENCY),
                  out_first >= 0 && out_second <= ANG_OUT_MAX &&
                  out_second >= -ANG_OUT_MAX,
                  "polar result outside magnitude or angle range")

endmodule
